// File: sv/rpl_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the reference picture list structure parser.
// No dependencies; every other file of the block imports this package.
package rpl_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_LONG_TERM_EN  = 3'd0;
	localparam logic [2:0] CFG_INTER_LAYER_EN = 3'd1;
	localparam logic [2:0] CFG_WEIGHTED_ANY  = 3'd2;
	localparam logic [2:0] CFG_POC_LSB_M4    = 3'd3;
	localparam logic [2:0] CFG_LISTS_L0      = 3'd4;
	localparam logic [2:0] CFG_LISTS_L1      = 3'd5;

	// Entry kinds
	localparam logic [1:0] KIND_SHORT = 2'd0;
	localparam logic [1:0] KIND_LONG  = 2'd1;
	localparam logic [1:0] KIND_INTER = 2'd2;
	localparam logic [1:0] KIND_EMPTY = 2'd3;

	// Longest Exp-Golomb prefix accepted
	localparam logic [4:0] UE_MAX_ZEROS = 5'd15;
	// Longest long-term POC LSB field
	localparam logic [4:0] LSB_MAX_BITS = 5'd16;

	typedef enum logic [8:0] {
		PH_IDLE  = 9'b000000001,
		PH_COUNT = 9'b000000010,
		PH_HDR   = 9'b000000100,
		PH_IL    = 9'b000001000,
		PH_ST    = 9'b000010000,
		PH_DELTA = 9'b000100000,
		PH_SIGN  = 9'b001000000,
		PH_LSB   = 9'b010000000,
		PH_ILIDX = 9'b100000000
	} rpl_phase_t;

	typedef struct packed {
		logic       long_term_enabled;
		logic       inter_layer_enabled;
		logic       weighted_any;
		logic [3:0] poc_lsb_bits_minus4;
		logic [6:0] lists_count_l0;
		logic [6:0] lists_count_l1;
	} rpl_cfg_t;

	typedef struct packed {
		logic       start_req;
		logic       list_select;
		logic [6:0] struct_index;
		logic       bit_in;
	} rpl_item_t;

	// Exp-Golomb shift state
	typedef struct packed {
		logic [4:0]  zero_count;
		logic [16:0] shift_value;
		logic [4:0]  bits_left;
	} rpl_ue_t;

	typedef struct packed {
		logic ready;
		logic overflow;
	} rpl_ue_status_t;

	// Parser state of fixed width; entry counters live beside it
	typedef struct packed {
		rpl_phase_t  phase;
		rpl_ue_t     ue;
		logic [4:0]  long_term_counter;
		logic        header_flag;
		logic [15:0] delta_held;
		logic [6:0]  struct_held;
		logic        list_held;
	} rpl_state_t;

	typedef struct packed {
		logic [4:0]  entry_index;
		logic [1:0]  entry_kind;
		logic [15:0] coded_value;
		logic [15:0] delta_magnitude;
		logic        delta_sign;
		logic        header_long_term;
		logic [4:0]  long_term_slot;
		logic [5:0]  entry_total;
		logic        last;
		logic        error;
	} rpl_result_t;

endpackage

// File: sv/rpl_expg.sv
`timescale 1ns / 1ps
// One bit step of the unsigned Exp-Golomb decoder: prefix count, then suffix.
// Depends on rpl_pkg.
module rpl_expg (
	input  rpl_pkg::rpl_ue_t        ue,
	input  logic                    bit_in,
	output rpl_pkg::rpl_ue_t        ue_next,
	output rpl_pkg::rpl_ue_status_t status
);
	import rpl_pkg::*;

	// Count leading zeros until the marker bit, then shift in the suffix
	always_comb begin
		ue_next = ue;
		status = '0;
		if (ue.shift_value == 17'd0) begin
			if (bit_in) begin
				ue_next.shift_value = 17'd1;
				ue_next.bits_left = ue.zero_count;
				status.ready = (ue.zero_count == 5'd0);
			end else if (ue.zero_count >= UE_MAX_ZEROS) begin
				status.overflow = 1'b1;
			end else begin
				ue_next.zero_count = ue.zero_count + 5'd1;
			end
		end else begin
			ue_next.shift_value = {ue.shift_value[15:0], bit_in};
			ue_next.bits_left = ue.bits_left - 5'd1;
			status.ready = (ue.bits_left == 5'd1);
		end
	end

endmodule

// File: sv/rpl_step.sv
`timescale 1ns / 1ps
// Next-state and result logic of the parser for one bitstream bit.
// Depends on rpl_pkg and rpl_expg.
module rpl_step #(
	parameter int MAX_ENTRIES = 32,
	parameter int CNT_W = 6
) (
	input  rpl_pkg::rpl_cfg_t    cfg,
	input  rpl_pkg::rpl_item_t   item,
	input  rpl_pkg::rpl_state_t  st,
	input  logic [CNT_W-1:0]     entry_cnt,
	input  logic [CNT_W-1:0]     entry_tot,
	output rpl_pkg::rpl_state_t  st_next,
	output logic [CNT_W-1:0]     entry_cnt_next,
	output logic [CNT_W-1:0]     entry_tot_next,
	output logic                 res_valid,
	output rpl_pkg::rpl_result_t res
);
	import rpl_pkg::*;

	rpl_state_t     w;
	logic [CNT_W-1:0] w_cnt, w_tot;
	rpl_ue_t        ue_nx;
	rpl_ue_status_t ue_st;

	function automatic rpl_state_t ue_begin(input rpl_state_t s, input rpl_phase_t ph);
		rpl_state_t r;
		r = s;
		r.phase = ph;
		r.ue = '0;
		return r;
	endfunction

	function automatic rpl_state_t begin_entry(input rpl_state_t s, input rpl_cfg_t c);
		rpl_state_t r;
		r = s;
		if (c.inter_layer_enabled) begin
			r.phase = PH_IL;
		end else if (c.long_term_enabled) begin
			r.phase = PH_ST;
		end else begin
			r = ue_begin(s, PH_DELTA);
		end
		return r;
	endfunction

	function automatic logic [16:0] mag_of(input logic [15:0] d, input logic wa,
	                                       input logic cnt_nz);
		logic [16:0] r;
		r = (wa && cnt_nz) ? {1'b0, d} : {1'b0, d} + 17'd1;
		return r;
	endfunction

	function automatic rpl_result_t fill(input logic [1:0] kind, input logic [15:0] coded,
	                                     input logic [15:0] mag, input logic sign,
	                                     input logic last_f, input logic err_f,
	                                     input logic [4:0] idx, input logic hdr,
	                                     input logic [4:0] slot, input logic [5:0] tot);
		rpl_result_t r;
		r.entry_index = idx;
		r.entry_kind = kind;
		r.coded_value = coded;
		r.delta_magnitude = mag;
		r.delta_sign = sign;
		r.header_long_term = hdr;
		r.long_term_slot = slot;
		r.entry_total = tot;
		r.last = last_f;
		r.error = err_f;
		return r;
	endfunction

	// Apply a start word before the bit is decoded
	always_comb begin
		w = st;
		w_cnt = entry_cnt;
		w_tot = entry_tot;
		if (item.start_req) begin
			w.list_held = item.list_select;
			w.struct_held = item.struct_index;
			w.long_term_counter = '0;
			w.header_flag = 1'b0;
			w.delta_held = '0;
			w = ue_begin(w, PH_COUNT);
			w_cnt = '0;
			w_tot = '0;
		end
	end

	rpl_expg u_expg (
		.ue      (w.ue),
		.bit_in  (item.bit_in),
		.ue_next (ue_nx),
		.status  (ue_st)
	);

	// Decode the bit in the current phase
	always_comb begin
		rpl_state_t  nx;
		logic        fin, fail, lt_bump, last_f;
		logic [1:0]  f_kind;
		logic [15:0] f_coded, f_mag;
		logic        f_sign;
		logic [16:0] v, mag;
		logic [6:0]  cnt_sel;
		logic [4:0]  n_lsb, bl;
		logic [16:0] sh;

		nx = w;
		entry_cnt_next = w_cnt;
		entry_tot_next = w_tot;
		res_valid = 1'b0;
		res = '0;
		fin = 1'b0;
		fail = 1'b0;
		lt_bump = 1'b0;
		f_kind = KIND_SHORT;
		f_coded = '0;
		f_mag = '0;
		f_sign = 1'b0;
		v = ue_nx.shift_value - 17'd1;
		mag = mag_of(w.delta_held, cfg.weighted_any, w_cnt != '0);
		cnt_sel = w.list_held ? cfg.lists_count_l1 : cfg.lists_count_l0;
		n_lsb = {1'b0, cfg.poc_lsb_bits_minus4} + 5'd4;
		if (n_lsb > LSB_MAX_BITS) begin
			n_lsb = LSB_MAX_BITS;
		end
		bl = (w.ue.bits_left != 5'd0) ? w.ue.bits_left - 5'd1 : 5'd0;
		sh = {w.ue.shift_value[15:0], item.bit_in};
		last_f = ({1'b0, w_cnt} + 1'b1) >= {1'b0, w_tot};

		case (w.phase)
			PH_COUNT: begin
				nx.ue = ue_nx;
				if (ue_st.overflow) begin
					fail = 1'b1;
				end else if (ue_st.ready) begin
					if (v > 17'(MAX_ENTRIES)) begin
						fail = 1'b1;
					end else begin
						entry_tot_next = CNT_W'(v);
						nx.header_flag = 1'b1;
						if (v == 17'd0) begin
							res_valid = 1'b1;
							res = fill(KIND_EMPTY, '0, '0, 1'b0, 1'b1, 1'b0, 5'(w_cnt),
							           1'b1, w.long_term_counter, 6'd0);
							nx.phase = PH_IDLE;
						end else if (cfg.long_term_enabled && (w.struct_held < cnt_sel)) begin
							nx.phase = PH_HDR;
						end else begin
							nx = begin_entry(nx, cfg);
						end
					end
				end
			end
			PH_HDR: begin
				nx.header_flag = item.bit_in;
				nx = begin_entry(nx, cfg);
			end
			PH_IL: begin
				if (item.bit_in) begin
					nx = ue_begin(w, PH_ILIDX);
				end else if (cfg.long_term_enabled) begin
					nx.phase = PH_ST;
				end else begin
					nx = ue_begin(w, PH_DELTA);
				end
			end
			PH_ST: begin
				if (item.bit_in) begin
					nx = ue_begin(w, PH_DELTA);
				end else if (w.header_flag) begin
					fin = 1'b1;
					f_kind = KIND_LONG;
				end else begin
					nx.phase = PH_LSB;
					nx.ue.shift_value = '0;
					nx.ue.bits_left = n_lsb;
				end
			end
			PH_DELTA: begin
				nx.ue = ue_nx;
				if (ue_st.overflow) begin
					fail = 1'b1;
				end else if (ue_st.ready) begin
					nx.delta_held = v[15:0];
					if (mag_of(v[15:0], cfg.weighted_any, w_cnt != '0) != 17'd0) begin
						nx.phase = PH_SIGN;
					end else begin
						fin = 1'b1;
						f_kind = KIND_SHORT;
						f_coded = v[15:0];
					end
				end
			end
			PH_SIGN: begin
				fin = 1'b1;
				f_kind = KIND_SHORT;
				f_coded = w.delta_held;
				f_mag = mag[15:0];
				f_sign = item.bit_in;
			end
			PH_LSB: begin
				nx.ue.shift_value = sh;
				nx.ue.bits_left = bl;
				if (bl == 5'd0) begin
					fin = 1'b1;
					f_kind = KIND_LONG;
					f_coded = sh[15:0];
					lt_bump = 1'b1;
				end
			end
			PH_ILIDX: begin
				nx.ue = ue_nx;
				if (ue_st.overflow) begin
					fail = 1'b1;
				end else if (ue_st.ready) begin
					fin = 1'b1;
					f_kind = KIND_INTER;
					f_coded = v[15:0];
				end
			end
			default: begin
				nx.phase = PH_IDLE;
			end
		endcase

		// Close a finished entry and move to the next one, or to idle after the last
		if (fin) begin
			res_valid = 1'b1;
			res = fill(f_kind, f_coded, f_mag, f_sign, last_f, 1'b0, 5'(w_cnt),
			           w.header_flag, w.long_term_counter, 6'(w_tot));
			entry_cnt_next = w_cnt + 1'b1;
			if (last_f) begin
				nx.phase = PH_IDLE;
			end else begin
				nx = begin_entry(nx, cfg);
			end
			if (lt_bump) begin
				nx.long_term_counter = w.long_term_counter + 5'd1;
			end
		end

		// Report a bad code or count and stop
		if (fail) begin
			res_valid = 1'b1;
			res = fill(KIND_EMPTY, '0, '0, 1'b0, 1'b1, 1'b1, 5'(w_cnt),
			           w.header_flag, w.long_term_counter, 6'(w_tot));
			nx.phase = PH_IDLE;
		end

		st_next = nx;
	end

endmodule

// File: sv/ref_pic_list_syntax_parser.sv
`timescale 1ns / 1ps
// Top level of the reference picture list structure parser: configuration
// registers, input register, parser state and result register.
// Depends on rpl_pkg, rpl_step and rpl_expg.

// The parser takes one bitstream bit per word and sustains one word per
// clock cycle while the output side is not stalling. A word is held in the
// input register while the step logic decodes it against the parser state,
// and any entry it finishes lands in the result register, which drives the
// output. The input stalls only while the result register holds a word that
// the output side is stalling. Configuration is to be written through the
// write port while the parser is idle; the block itself does not enforce this.
module ref_pic_list_syntax_parser #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        start_req,
	input  logic        list_select,
	input  logic [6:0]  struct_index,
	input  logic        bit_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  entry_index,
	output logic [1:0]  entry_kind,
	output logic [15:0] coded_value,
	output logic [15:0] delta_magnitude,
	output logic        delta_sign,
	output logic        header_long_term,
	output logic [4:0]  long_term_slot,
	output logic [5:0]  entry_total,
	output logic        last,
	output logic        error
);
	import rpl_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	rpl_cfg_t         cfg_q;
	logic             valid_s1;
	rpl_item_t        item_s1;
	rpl_state_t       st_q, st_next;
	logic [CNT_W-1:0] cnt_q, tot_q, cnt_next, tot_next;
	logic             step_valid;
	rpl_result_t      step_res;
	logic             valid_s2;
	rpl_result_t      res_s2;
	logic             adv;
	logic             in_take;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LONG_TERM_EN:   cfg_q.long_term_enabled <= cfg_data[0];
				CFG_INTER_LAYER_EN: cfg_q.inter_layer_enabled <= cfg_data[0];
				CFG_WEIGHTED_ANY:   cfg_q.weighted_any <= cfg_data[0];
				CFG_POC_LSB_M4:     cfg_q.poc_lsb_bits_minus4 <= cfg_data[3:0];
				CFG_LISTS_L0:       cfg_q.lists_count_l0 <= cfg_data;
				CFG_LISTS_L1:       cfg_q.lists_count_l1 <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance when the result register is free or being drained
	assign adv = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign in_take = in_valid && !in_stall;

	// Hold the accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= '{start_req, list_select, struct_index, bit_in};
		end
	end

	rpl_step #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.CNT_W       (CNT_W)
	) u_step (
		.cfg            (cfg_q),
		.item           (item_s1),
		.st             (st_q),
		.entry_cnt      (cnt_q),
		.entry_tot      (tot_q),
		.st_next        (st_next),
		.entry_cnt_next (cnt_next),
		.entry_tot_next (tot_next),
		.res_valid      (step_valid),
		.res            (step_res)
	);

	// Update parser state as the held word is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, default: '0};
			cnt_q <= '0;
			tot_q <= '0;
		end else if (valid_s1 && adv) begin
			st_q <= st_next;
			cnt_q <= cnt_next;
			tot_q <= tot_next;
		end
	end

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && step_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && step_valid) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid = valid_s2;
	assign entry_index = res_s2.entry_index;
	assign entry_kind = res_s2.entry_kind;
	assign coded_value = res_s2.coded_value;
	assign delta_magnitude = res_s2.delta_magnitude;
	assign delta_sign = res_s2.delta_sign;
	assign header_long_term = res_s2.header_long_term;
	assign long_term_slot = res_s2.long_term_slot;
	assign entry_total = res_s2.entry_total;
	assign last = res_s2.last;
	assign error = res_s2.error;

	// An error word always closes the structure as an empty-kind result
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.error |-> res_s2.last && (res_s2.entry_kind == KIND_EMPTY))
		else $error("error result not marked last and empty");

	// A final result returns the parser to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && step_valid && step_res.last |=> st_q.phase == PH_IDLE)
		else $error("parser not idle after final result");

	// Inside the entry loop the counter stays below the decoded total
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase != PH_IDLE) && (st_q.phase != PH_COUNT) |-> cnt_q < tot_q)
		else $error("entry counter reached total inside structure");

endmodule
